FILE: rtl/cre_pkg.sv
// Shared types, constants and helpers for the capture run-length encoder.
// No dependencies; imported by every module of the block except cre_lane.
package cre_pkg;

  localparam int unsigned RUN_W   = 15;
  localparam int unsigned CNT_W   = RUN_W + 1;
  localparam int unsigned RUN_MAX = 16384;

  typedef struct packed {
    logic first_word;
    logic last_word;
  } cre_flags_t;

  // Clamps a widened run count to the saturation limit RUN_MAX.
  function automatic logic [RUN_W-1:0] cre_sat_width(input logic [CNT_W-1:0] v);
    logic [RUN_W-1:0] r;
    if (v > CNT_W'(RUN_MAX)) begin
      r = RUN_W'(RUN_MAX);
    end else begin
      r = v[RUN_W-1:0];
    end
    return r;
  endfunction

endpackage

FILE: rtl/cre_lane.sv
// One sample lane: applies the inversion and flags a level change against the
// previous sample of the same word. No package dependencies.
module cre_lane (
  input  logic sample,
  input  logic prev_sample,
  input  logic invert,
  output logic level,
  output logic change
);

  assign level  = sample ^ invert;
  // Inversion applies to both samples, so it cancels out of the comparison.
  assign change = sample ^ prev_sample;

endmodule

FILE: rtl/cre_merge.sv
// Merging stage: walks one word's change flags, one run per cycle when the
// output is free, and keeps the open run across words. Depends on cre_pkg.
module cre_merge
  import cre_pkg::*;
#(
  parameter int WORD_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 lane_valid,
  input  logic [WORD_BITS-1:0] lane_bits,
  input  logic [WORD_BITS-1:1] lane_bounds,
  input  cre_flags_t           lane_flags,
  output logic                 lane_take,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [RUN_W:0]       out_data,
  output logic                 out_last
);

  localparam int POS_W = $clog2(WORD_BITS);

  logic                 busy;
  logic [WORD_BITS-1:0] mask;
  logic [POS_W-1:0]     start;
  logic [CNT_W-1:0]     carry;
  logic                 lvl;
  logic                 flush;
  logic                 level_q;
  logic [RUN_W-1:0]     rlen_q;

  logic                 has_b;
  logic [WORD_BITS-1:0] rest;
  logic                 more;
  logic [POS_W-1:0]     pos;
  logic [RUN_W-1:0]     bnd_w;
  logic [CNT_W-1:0]     carry_n;
  logic [POS_W-1:0]     start_n;
  logic                 lvl_n;
  logic [RUN_W-1:0]     end_w;
  logic                 adv;
  logic                 step;
  logic                 emit;
  logic                 finish;
  logic                 commit_level;
  logic [RUN_W-1:0]     commit_len;
  logic                 src_level;
  logic [RUN_W-1:0]     src_len;
  logic                 open_run;

  assign has_b = |mask;
  assign rest  = mask & (mask - WORD_BITS'(1));
  assign more  = |rest;

  // Lowest pending change position.
  always_comb begin
    pos = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (mask[i]) begin
        pos = POS_W'(i);
      end
    end
  end

  assign bnd_w   = cre_sat_width(carry + CNT_W'(pos) - CNT_W'(start));
  assign carry_n = has_b ? '0 : carry;
  assign start_n = has_b ? pos : start;
  assign lvl_n   = has_b ? ~lvl : lvl;
  assign end_w   = cre_sat_width(carry_n + CNT_W'(WORD_BITS) - CNT_W'(start_n));

  assign adv    = !out_valid || out_ready;
  assign step   = busy && adv;
  assign emit   = step && (has_b || flush);
  assign finish = step && (has_b ? (!more && !flush) : 1'b1);

  assign commit_level = lvl_n;
  assign commit_len   = flush ? '0 : end_w;

  // The next word sees the state this word leaves, even in the cycle it ends.
  assign src_level = finish ? commit_level : level_q;
  assign src_len   = finish ? commit_len : rlen_q;
  assign open_run  = !lane_flags.first_word && (src_len != '0);
  assign lane_take = lane_valid && (!busy || finish);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
      level_q   <= 1'b0;
      rlen_q    <= '0;
    end else begin
      if (finish) begin
        level_q <= commit_level;
        rlen_q  <= commit_len;
      end
      if (lane_take) begin
        busy  <= 1'b1;
        mask  <= {lane_bounds, open_run && (lane_bits[0] != src_level)};
        start <= '0;
        carry <= open_run ? {1'b0, src_len} : '0;
        lvl   <= open_run ? src_level : lane_bits[0];
        flush <= lane_flags.last_word;
      end else if (finish) begin
        busy <= 1'b0;
      end else if (step && has_b) begin
        mask  <= rest;
        start <= pos;
        carry <= '0;
        lvl   <= ~lvl;
      end
      if (adv) begin
        out_valid <= emit;
        if (emit) begin
          out_data <= {has_b ? bnd_w : end_w, lvl};
          out_last <= has_b ? (!more && !flush) : 1'b1;
        end
      end
    end
  end

endmodule

FILE: rtl/capture_run_length_encoder_top.sv
// Run-length encoder for captured logic samples: top level.
// Depends on cre_pkg, cre_lane and cre_merge.
//
// Input stream (s_axis): one word of WORD_BITS samples per transaction, bit 0
// earliest. tuser marks the first word of a capture, tlast the final word,
// which flushes the open run. The inversion register is to be written through
// cfg_wr_en / cfg_wr_data only while the block is idle; the block does not
// enforce this. Output stream (m_axis): one finished run per transaction,
// tdata holding the level and the saturating width; tlast marks the last run
// of an input word. An accepted word waits in the lane register and is taken
// into the merging stage when that is free or in the cycle the previous word
// finishes there; each run passes through the output register. While the
// receiver does not stall, the merging stage emits one run per cycle. A stalled
// receiver holds the output register and, behind it, the merging stage and lane
// register; s_axis_tready drops once both are full.
// Reset clears the open run (level 0, no run open), the inversion register
// and all pending transactions.
module capture_run_length_encoder_top
  import cre_pkg::*;
#(
  parameter int WORD_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic                 cfg_wr_data,     // invert_samples
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [WORD_BITS-1:0] s_axis_tdata,    // [WORD_BITS-1:0] sample_word
  input  logic                 s_axis_tuser,    // first_word
  input  logic                 s_axis_tlast,    // last_word
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [RUN_W:0]       m_axis_tdata,    // [0] run_level, [15:1] run_width
  output logic                 m_axis_tlast     // last_of_item
);

  logic                 invert;
  logic [WORD_BITS-1:0] bits;
  logic [WORD_BITS-1:1] bounds;
  logic                 lane_valid;
  logic [WORD_BITS-1:0] lane_bits;
  logic [WORD_BITS-1:1] lane_bounds;
  cre_flags_t           lane_flags;
  logic                 lane_take;
  logic                 accept;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = !lane_valid || lane_take;

  assign bits[0] = s_axis_tdata[0] ^ invert;

  for (genvar i = 1; i < WORD_BITS; i++) begin : g_lane
    cre_lane u_lane (
      .sample      (s_axis_tdata[i]),
      .prev_sample (s_axis_tdata[i-1]),
      .invert      (invert),
      .level       (bits[i]),
      .change      (bounds[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      invert     <= 1'b0;
      lane_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        invert <= cfg_wr_data;
      end
      if (accept) begin
        lane_valid             <= 1'b1;
        lane_bits              <= bits;
        lane_bounds            <= bounds;
        lane_flags.first_word  <= s_axis_tuser;
        lane_flags.last_word   <= s_axis_tlast;
      end else if (lane_take) begin
        lane_valid <= 1'b0;
      end
    end
  end

  cre_merge #(
    .WORD_BITS (WORD_BITS)
  ) u_merge (
    .clk         (clk),
    .rst         (rst),
    .lane_valid  (lane_valid),
    .lane_bits   (lane_bits),
    .lane_bounds (lane_bounds),
    .lane_flags  (lane_flags),
    .lane_take   (lane_take),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_data    (m_axis_tdata),
    .out_last    (m_axis_tlast)
  );

endmodule

FILE: rtl/cre_checker.sv
// Port-level checks for the capture run-length encoder, bound to the top level.
// Depends on cre_pkg and capture_run_length_encoder_top.
module cre_checker
  import cre_pkg::*;
(
  input logic           clk,
  input logic           rst,
  input logic           s_axis_tready,
  input logic           m_axis_tvalid,
  input logic           m_axis_tready,
  input logic [RUN_W:0] m_axis_tdata,
  input logic           m_axis_tlast
);

  // Reset empties the output register.
  a_reset_out: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

  // Reset empties the lane register, so a word can be taken at once.
  a_reset_ready: assert property (@(posedge clk) rst |=> s_axis_tready)
    else $error("input not ready after reset");

  // A reported run is never empty and never wider than the saturation limit.
  a_width_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[RUN_W:1] != '0) &&
                      (m_axis_tdata[RUN_W:1] <= RUN_W'(RUN_MAX)))
    else $error("run width out of range");

  // A stalled run holds still.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output changed while stalled");

endmodule

bind capture_run_length_encoder_top cre_checker u_cre_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

FILE: dv/tb_top.sv
// Self-checking testbench for capture_run_length_encoder_top.
// Depends on cre_pkg and the encoder RTL; an internal predictor models the run encoding.
`timescale 1ns / 1ps

module tb_top
  import cre_pkg::*;
();

  localparam int WORD_BITS = 32;

  typedef struct packed {
    logic             level;
    logic [RUN_W-1:0] width;
    logic             ends_word;
  } sample_run_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_wr_en = 1'b0;
  logic                 cfg_wr_data = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [WORD_BITS-1:0] s_axis_tdata = '0;  // [31:0] sample_word
  logic                 s_axis_tuser = 1'b0;  // first_word
  logic                 s_axis_tlast = 1'b0;  // last_word
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [RUN_W:0]       m_axis_tdata;  // [0] run_level, [15:1] run_width
  logic                 m_axis_tlast;  // last_of_item

  // Predictor state, mirroring the encoder.
  logic             invert_cfg = 1'b0;
  logic             open_level = 1'b0;
  logic [RUN_W-1:0] open_length = '0;

  sample_run_t expected_runs[$];
  int          err_count = 0;
  bit          idle_en = 1'b1;
  int          stall_left = 0;
  int          words_sent = 0;

  capture_run_length_encoder_top #(
    .WORD_BITS(WORD_BITS)
  ) uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    err_count++;
  endtask

  // Works out the runs that one sample word closes and queues them.
  function automatic void encode_word(input logic [WORD_BITS-1:0] word, input logic is_first,
                                      input logic is_final);
    int          emitted;
    logic        smp;
    sample_run_t r;
    emitted = 0;
    if (is_first) begin
      open_level  = word[0] ^ invert_cfg;
      open_length = '0;
    end
    for (int j = 0; j < WORD_BITS; j++) begin
      smp = word[j] ^ invert_cfg;
      if (open_length == 0) begin
        open_level  = smp;
        open_length = RUN_W'(1);
      end else if (smp == open_level) begin
        if (open_length < RUN_W'(RUN_MAX)) open_length++;
      end else begin
        r = '{level: open_level, width: open_length, ends_word: 1'b0};
        expected_runs.push_back(r);
        emitted++;
        open_level  = smp;
        open_length = RUN_W'(1);
      end
    end
    if (is_final && open_length != 0) begin
      r = '{level: open_level, width: open_length, ends_word: 1'b0};
      expected_runs.push_back(r);
      emitted++;
      open_length = '0;
    end
    if (emitted > 0) expected_runs[$].ends_word = 1'b1;
  endfunction

  task automatic send_word(input logic [WORD_BITS-1:0] word, input logic is_first,
                           input logic is_final);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    encode_word(word, is_first, is_final);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    s_axis_tuser  <= is_first;
    s_axis_tlast  <= is_final;
    do @(posedge clk); while (!s_axis_tready);
    words_sent++;
  endtask

  // Stops sending and waits until every queued run has been seen, then waits on
  // so that words still in flight that close no run are drained.
  task automatic wait_for_runs();
    s_axis_tvalid <= 1'b0;
    while (expected_runs.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_invert(input logic v);
    wait_for_runs();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    invert_cfg = v;
  endtask

  function automatic logic [WORD_BITS-1:0] gen_word();
    logic [WORD_BITS-1:0] w;
    case ($urandom_range(0, 4))
      0: w = $urandom;
      1: w = $urandom_range(0, 1) ? '1 : '0;
      2: w = $urandom & $urandom & $urandom;
      3: w = $urandom | $urandom | $urandom;
      default: w = ('1 << $urandom_range(0, 31)) ^ ('1 << $urandom_range(0, 31));
    endcase
    return w;
  endfunction

  // Receiver: checks each run against the oldest prediction, then decides
  // on stalls for the coming cycles.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_runs.size() == 0) begin
        report_mismatch($sformatf("run with nothing expected: tdata=%h tlast=%b",
                                  m_axis_tdata, m_axis_tlast));
      end else begin
        sample_run_t want;
        want = expected_runs.pop_front();
        if (m_axis_tdata[0] !== want.level)
          report_mismatch($sformatf("run_level %b, expected %b", m_axis_tdata[0], want.level));
        if (m_axis_tdata[RUN_W:1] !== want.width)
          report_mismatch($sformatf("run_width %0d, expected %0d", m_axis_tdata[RUN_W:1],
                                    want.width));
        if (m_axis_tlast !== want.ends_word)
          report_mismatch($sformatf("last_of_item %b, expected %b", m_axis_tlast,
                                    want.ends_word));
      end
    end
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 4);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Extremes, single-bit final runs, the 33-run word and capture marks.
  task automatic test_directed();
    set_invert(1'b0);
    send_word(32'h0000_0001, 1'b0, 1'b0);  // no run open after reset, no first mark
    send_word(32'h0000_0000, 1'b0, 1'b1);
    send_word(32'h0000_0000, 1'b1, 1'b1);
    send_word(32'hFFFF_FFFF, 1'b1, 1'b1);
    send_word(32'h8000_0000, 1'b1, 1'b1);  // final run one sample wide
    send_word(32'h0000_FFFF, 1'b1, 1'b0);
    send_word(32'h5555_5555, 1'b0, 1'b1);  // closes the carried run and 32 more
    send_word(32'h5555_5555, 1'b1, 1'b1);
    send_word(32'h0000_00F0, 1'b0, 1'b0);  // fresh capture after a flush
    send_word(32'h0000_0000, 1'b0, 1'b0);  // closes no run
    send_word(32'hFFFF_FFFF, 1'b1, 1'b0);  // first mark restarts mid capture
    send_word(32'h7FFF_FFFF, 1'b0, 1'b1);
    set_invert(1'b1);
    send_word(32'h0000_0000, 1'b1, 1'b1);
    send_word(32'hF0F0_0F0F, 1'b1, 1'b0);
    send_word(32'h1234_5678, 1'b0, 1'b0);
    send_word(32'hFFFF_FFFE, 1'b0, 1'b1);
    send_word(32'h0000_0001, 1'b1, 1'b1);
    wait_for_runs();
  endtask

  // A run longer than the saturation limit RUN_MAX, with inverted samples.
  task automatic test_long_run();
    set_invert(1'b1);
    for (int k = 0; k < 513; k++) send_word(32'h0000_0000, k == 0, 1'b0);
    send_word(32'hFFFF_0000, 1'b0, 1'b1);
    wait_for_runs();
  endtask

  // Captures of random length and content, with some broken marks.
  task automatic test_random_captures(input int target);
    int n;
    int mid_pause_at;
    logic mark_first;
    logic mark_final;
    mid_pause_at = words_sent + target / 2;
    target = words_sent + target;
    while (words_sent < target) begin
      if (words_sent >= mid_pause_at) begin
        set_invert(1'($urandom_range(0, 1)));
        mid_pause_at = target + 1;
      end
      n = $urandom_range(1, 10);
      for (int i = 0; i < n; i++) begin
        mark_first = (i == 0);
        mark_final = (i == n - 1);
        if ($urandom_range(0, 9) == 0) mark_first = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 9) == 0) mark_final = 1'($urandom_range(0, 1));
        send_word(gen_word(), mark_first, mark_final);
      end
    end
    wait_for_runs();
  endtask

  // Back-to-back traffic with neither side idling.
  task automatic test_full_rate();
    set_invert(1'b0);
    idle_en = 1'b0;
    for (int i = 0; i < 24; i++)
      send_word(gen_word(), $urandom_range(0, 7) == 0, $urandom_range(0, 3) == 0);
    send_word(gen_word(), 1'b0, 1'b1);
    wait_for_runs();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_long_run();
    test_random_captures(25);
    set_invert(1'b1);
    test_random_captures(25);
    test_full_rate();
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
